// ===== rtl/core/ctb_pkg.sv =====
// Package for the countdown timer bank: sizes, request and event codes,
// register indexes, reset values, the stored timer entry, the event record and states.
// No dependencies.
package ctb_pkg;

    localparam int NUM_TIMERS = 20;
    localparam int ADDR_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    localparam int REQ_W      = 3;
    localparam int TIMER_W    = 5;
    localparam int COUNT_W    = 16;
    localparam int TIME_W     = 48;
    localparam int MPC_W      = 20;
    localparam int PROD_W     = COUNT_W + MPC_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = MPC_W;

    // request codes
    localparam logic [REQ_W-1:0] REQ_START = 3'd0;
    localparam logic [REQ_W-1:0] REQ_STOP  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_TRIP  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd3;
    localparam logic [REQ_W-1:0] REQ_QUERY = 3'd4;
    localparam logic [REQ_W-1:0] REQ_TICK  = 3'd5;

    // event codes
    localparam logic [2:0] EV_ACK     = 3'd0;
    localparam logic [2:0] EV_QUERY   = 3'd1;
    localparam logic [2:0] EV_SERVICE = 3'd2;
    localparam logic [2:0] EV_FINISH  = 3'd3;
    localparam logic [2:0] EV_DONE    = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MPC  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PROT = 1'b1;

    localparam logic [MPC_W-1:0]   MPC_RESET  = 20'd10000;
    localparam logic [TIMER_W-1:0] PROT_RESET = 5'd11;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               tripped;
        logic [TIME_W-1:0]  deadline;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [2:0]         event_kind;
        logic [TIMER_W-1:0] event_timer;
        logic [COUNT_W-1:0] remaining;
        logic               last;
    } t_evt;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CMD   = 4'b0010,
        S_QUERY = 4'b0100,
        S_TICK  = 4'b1000
    } t_state;

endpackage

// ===== rtl/core/ctb_intf.sv =====
// Handshake interfaces of the countdown timer bank: request, event and
// configuration channels. Depends on ctb_pkg.
interface ctb_req_if import ctb_pkg::*;;
    logic               valid;
    logic               ready;
    logic [REQ_W-1:0]   req_type;
    logic [TIMER_W-1:0] timer_index;
    logic [COUNT_W-1:0] start_count;
    logic [TIME_W-1:0]  now_us;

    modport source (output valid, req_type, timer_index, start_count, now_us, input ready);
    modport sink   (input valid, req_type, timer_index, start_count, now_us, output ready);
endinterface

interface ctb_evt_if import ctb_pkg::*;;
    logic               valid;
    logic               ready;
    logic [2:0]         event_kind;
    logic [TIMER_W-1:0] event_timer;
    logic [COUNT_W-1:0] remaining;
    logic               last;

    modport source (output valid, event_kind, event_timer, remaining, last, input ready);
    modport sink   (input valid, event_kind, event_timer, remaining, last, output ready);
endinterface

interface ctb_cfg_if import ctb_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

// ===== rtl/core/ctb_ram.sv =====
// Generic simple dual-port RAM, one write and one read port, registered read.
// No dependencies.
module ctb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/countdown_timer_bank_top.sv =====
// Countdown timer bank: command sequencer around one timer-entry RAM.
// A command or query result is loaded into the output register from S_CMD or S_QUERY once it is free.
// The next request is taken only once the block is back in S_IDLE; a tick walks the entries
// one per cycle through the single RAM read port while the output is not stalled.
// Reset (synchronous, i_rst_n low): entry valid bits cleared so every timer reads idle,
// registers back to defaults; no clearing pass over the RAM.
module countdown_timer_bank_top import ctb_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    ctb_req_if.sink   i_req,
    ctb_cfg_if.sink   i_cfg,
    ctb_evt_if.source o_evt
);

    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_t, n_t;
    logic                r_ok, n_ok;
    logic [REQ_W-1:0]    r_req;
    logic [TIMER_W-1:0]  r_idx;
    logic [COUNT_W-1:0]  r_cnt;
    logic [TIME_W-1:0]   r_now;
    logic [PROD_W-1:0]   r_prod;
    logic [MPC_W-1:0]    r_mpc;
    logic [TIMER_W-1:0]  r_prot;
    logic [NUM_TIMERS-1:0] r_valid, n_valid;
    logic                r_out_valid;
    t_evt                r_out, n_out;

    logic                accept;
    logic                out_free;
    logic                out_load;
    logic [COUNT_W-1:0]  cnt_eff;
    logic                idx_ok;
    logic [TIME_W:0]     dl_sum;
    logic [TIME_W-1:0]   dl_sat;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
    t_entry              ram_wdata, ram_rdata, cur;
    logic                cur_valid;
    logic [COUNT_W-1:0]  dec_cnt;

    ctb_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_TIMERS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign accept      = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_evt.ready;

    assign cnt_eff = (i_req.start_count == '0) ? COUNT_W'(1) : i_req.start_count;
    assign idx_ok  = ({1'b0, i_req.timer_index} < (TIMER_W + 1)'(NUM_TIMERS));

    assign dl_sum = {1'b0, r_now} + (TIME_W + 1)'(r_prod);
    assign dl_sat = dl_sum[TIME_W] ? TIME_MAX : dl_sum[TIME_W-1:0];

    // entries never written since reset or cleared read as idle
    assign cur_valid = r_ok && r_valid[r_t];
    assign cur       = cur_valid ? ram_rdata : '0;
    assign dec_cnt   = cur.count - COUNT_W'(1);

    // the tick write-back of entry t goes with the read of t+1, apart from the last entry, whose
    // read is unused; commands write only after their own read, so no forwarding is needed
    always_comb begin
        n_state   = r_state;
        n_t       = r_t;
        n_ok      = r_ok;
        n_valid   = r_valid;
        n_out     = r_out;
        out_load  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_t;
        ram_wdata = '0;
        ram_raddr = r_t;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_t  = idx_ok ? i_req.timer_index[ADDR_W-1:0] : '0;
                    n_ok = idx_ok;
                    case (i_req.req_type)
                        REQ_START, REQ_STOP, REQ_TRIP, REQ_CLEAR: n_state = S_CMD;
                        REQ_QUERY: n_state = S_QUERY;
                        REQ_TICK: begin
                            n_t     = '0;
                            n_ok    = 1'b1;
                            n_state = S_TICK;
                        end
                        default: n_state = S_IDLE;
                    endcase
                    ram_raddr = n_t;
                end
            end
            S_CMD: begin
                if (out_free) begin
                    out_load          = 1'b1;
                    n_out.event_kind  = EV_ACK;
                    n_out.event_timer = (r_req == REQ_CLEAR) ? '0 : r_idx;
                    n_out.remaining   = '0;
                    n_out.last        = 1'b1;
                    n_state           = S_IDLE;
                    case (r_req)
                        REQ_START: begin
                            if (r_ok) begin
                                ram_we            = 1'b1;
                                ram_wdata.count   = r_cnt;
                                ram_wdata.tripped = 1'b0;
                                ram_wdata.deadline = dl_sat;
                                n_valid[r_t]      = 1'b1;
                            end
                        end
                        REQ_STOP: begin
                            if (r_ok) begin
                                n_valid[r_t] = 1'b0;
                            end
                        end
                        REQ_TRIP: begin
                            if (r_ok) begin
                                ram_we            = 1'b1;
                                ram_wdata.tripped = 1'b1;
                                n_valid[r_t]      = 1'b1;
                            end
                        end
                        REQ_CLEAR: begin
                            // a cleared timer's deadline is never looked at again
                            for (int i = 0; i < NUM_TIMERS; i++) begin
                                if (TIMER_W'(i) != r_prot) begin
                                    n_valid[i] = 1'b0;
                                end
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_QUERY: begin
                if (out_free) begin
                    out_load          = 1'b1;
                    n_out.event_kind  = EV_QUERY;
                    n_out.event_timer = r_idx;
                    n_out.remaining   = cur.count;
                    n_out.last        = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_TICK: begin
                if (r_ok) begin
                    n_out.event_timer = TIMER_W'(r_t);
                    n_out.last        = 1'b0;
                    n_out.remaining   = '0;
                    if (cur.tripped) begin
                        if (out_free) begin
                            out_load         = 1'b1;
                            n_out.event_kind = EV_FINISH;
                            n_valid[r_t]     = 1'b0;
                            n_ok             = 1'b0;
                        end
                    end else if (cur.count != '0) begin
                        if (r_now < cur.deadline) begin
                            if (out_free) begin
                                out_load         = 1'b1;
                                n_out.event_kind = EV_SERVICE;
                                n_out.remaining  = dec_cnt;
                                ram_we           = 1'b1;
                                n_ok             = 1'b0;
                                if (dec_cnt == '0) begin
                                    ram_wdata.tripped = 1'b1;
                                end else begin
                                    ram_wdata.count    = dec_cnt;
                                    ram_wdata.deadline = cur.deadline;
                                end
                            end
                        end else begin
                            // past its deadline: trips without an event
                            ram_we            = 1'b1;
                            ram_wdata.tripped = 1'b1;
                            n_ok              = 1'b0;
                        end
                    end else begin
                        n_ok = 1'b0;
                    end
                    // entry done: step to the next one
                    if (!n_ok) begin
                        n_ok = 1'b1;
                        if (r_t == ADDR_W'(NUM_TIMERS - 1)) begin
                            n_ok = 1'b0;
                        end else begin
                            n_t       = r_t + ADDR_W'(1);
                            ram_raddr = n_t;
                        end
                    end
                end else if (out_free) begin
                    // r_ok low here marks the walk finished: emit the done marker
                    out_load          = 1'b1;
                    n_out.event_kind  = EV_DONE;
                    n_out.event_timer = '0;
                    n_out.remaining   = '0;
                    n_out.last        = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_t         <= '0;
            r_ok        <= 1'b0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_mpc       <= MPC_RESET;
            r_prot      <= PROT_RESET;
        end else begin
            r_state <= n_state;
            r_t     <= n_t;
            r_ok    <= n_ok;
            r_valid <= n_valid;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_evt.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid) begin
                case (i_cfg.reg_index)
                    REG_MPC:  r_mpc  <= i_cfg.wr_data;
                    REG_PROT: r_prot <= i_cfg.wr_data[TIMER_W-1:0];
                    default:  r_mpc  <= r_mpc;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req  <= i_req.req_type;
            r_idx  <= i_req.timer_index;
            r_cnt  <= cnt_eff;
            r_now  <= i_req.now_us;
            r_prod <= PROD_W'(cnt_eff) * PROD_W'(r_mpc);
        end
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign o_evt.valid       = r_out_valid;
    assign o_evt.event_kind  = r_out.event_kind;
    assign o_evt.event_timer = r_out.event_timer;
    assign o_evt.remaining   = r_out.remaining;
    assign o_evt.last        = r_out.last;

    a_ram_we_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_CMD || r_state == S_TICK))
        else $error("RAM written outside a command or tick");

    a_tick_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TICK) |-> (r_t <= ADDR_W'(NUM_TIMERS - 1)))
        else $error("tick walk beyond last timer");

    a_write_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> r_valid[$past(ram_waddr)])
        else $error("written entry not marked valid");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TICK && !r_ok && out_free) |=>
            (r_state == S_IDLE && r_out_valid && r_out.last && r_out.event_kind == EV_DONE))
        else $error("tick did not end with a done marker");

    a_output_not_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> out_free)
        else $error("result loaded over a pending one");

endmodule

// ===== sim/tb_countdown_timer_bank_top.sv =====
`timescale 1ns / 100ps
// Testbench for countdown_timer_bank_top: a shadow model of the timer bank predicts the
// event stream, which is checked per transfer. Depends on ctb_pkg, ctb_intf and the RTL top.
module tb_countdown_timer_bank_top import ctb_pkg::*; ();

    localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd7;

    localparam int HOLD_CYCLES      = 400;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int IDLE_SETTLE      = 8;
    localparam int END_SETTLE       = 24;
    localparam int RANDOM_PER_PHASE = 23;

    // Shadow copy of the timer bank plus the queue of events still owed by the block
    class timer_bank_shadow;
        logic [COUNT_W-1:0] count_q    [NUM_TIMERS];
        logic               tripped_q  [NUM_TIMERS];
        logic [TIME_W-1:0]  deadline_q [NUM_TIMERS];
        logic [MPC_W-1:0]   mpc;
        logic [TIMER_W-1:0] prot;
        t_evt               owed_events [$];
        int                 mismatches;

        function new();
            mpc        = MPC_RESET;
            prot       = PROT_RESET;
            mismatches = 0;
            foreach (count_q[t]) begin
                count_q[t]    = '0;
                tripped_q[t]  = 1'b0;
                deadline_q[t] = '0;
            end
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_MPC) begin
                mpc = data[MPC_W-1:0];
            end else if (idx == REG_PROT) begin
                prot = data[TIMER_W-1:0];
            end
        endfunction

        function int pending();
            return owed_events.size();
        endfunction

        function t_evt mk(logic [2:0] k, logic [TIMER_W-1:0] t, logic [COUNT_W-1:0] r);
            return {k, t, r, 1'b0};
        endfunction

        function void halt_entry(int t);
            count_q[t]   = '0;
            tripped_q[t] = 1'b0;
        endfunction

        function void trip_entry(int t);
            tripped_q[t]  = 1'b1;
            count_q[t]    = '0;
            deadline_q[t] = '0;
        endfunction

        function void note_request(logic [REQ_W-1:0] kind, logic [TIMER_W-1:0] idx,
                                   logic [COUNT_W-1:0] cnt, logic [TIME_W-1:0] now);
            t_evt               evs [$];
            logic [COUNT_W-1:0] c;
            logic [63:0]        sum;
            bit                 hit;
            hit = (idx < NUM_TIMERS);
            case (kind)
                REQ_START: begin
                    if (hit) begin
                        c   = (cnt == '0) ? COUNT_W'(1) : cnt;
                        sum = 64'(now) + 64'(c) * 64'(mpc);
                        tripped_q[idx]  = 1'b0;
                        count_q[idx]    = c;
                        deadline_q[idx] = (sum > 64'(TIME_MAX)) ? TIME_MAX : sum[TIME_W-1:0];
                    end
                    evs.push_back(mk(EV_ACK, idx, '0));
                end
                REQ_STOP: begin
                    if (hit) halt_entry(idx);
                    evs.push_back(mk(EV_ACK, idx, '0));
                end
                REQ_TRIP: begin
                    if (hit) trip_entry(idx);
                    evs.push_back(mk(EV_ACK, idx, '0));
                end
                REQ_CLEAR: begin
                    for (int t = 0; t < NUM_TIMERS; t++)
                        if (t != int'(prot)) halt_entry(t);
                    evs.push_back(mk(EV_ACK, '0, '0));
                end
                REQ_QUERY: begin
                    evs.push_back(mk(EV_QUERY, idx, hit ? count_q[idx] : '0));
                end
                REQ_TICK: begin
                    for (int t = 0; t < NUM_TIMERS; t++) begin
                        if (tripped_q[t]) begin
                            halt_entry(t);
                            evs.push_back(mk(EV_FINISH, TIMER_W'(t), '0));
                        end else if (count_q[t] != '0) begin
                            if (now < deadline_q[t]) begin
                                count_q[t] = count_q[t] - 1'b1;
                                evs.push_back(mk(EV_SERVICE, TIMER_W'(t), count_q[t]));
                                if (count_q[t] == '0) trip_entry(t);
                            end else begin
                                // past the deadline: trips with no event this tick
                                trip_entry(t);
                            end
                        end
                    end
                    evs.push_back(mk(EV_DONE, '0, '0));
                end
                default: ;
            endcase
            if (evs.size() > 0) evs[evs.size()-1].last = 1'b1;
            foreach (evs[k]) owed_events.push_back(evs[k]);
        endfunction

        function void check_event(t_evt got);
            t_evt want;
            if (owed_events.size() == 0) begin
                $error("unexpected event: event_kind %0d event_timer %0d remaining %0d",
                       got.event_kind, got.event_timer, got.remaining);
                mismatches++;
                return;
            end
            want = owed_events.pop_front();
            if (got.event_kind !== want.event_kind) begin
                $error("event_kind: expected %0d, actual %0d", want.event_kind, got.event_kind);
                mismatches++;
            end
            if (got.event_timer !== want.event_timer) begin
                $error("event_timer: expected %0d, actual %0d",
                       want.event_timer, got.event_timer);
                mismatches++;
            end
            if (got.remaining !== want.remaining) begin
                $error("remaining: expected %0d, actual %0d", want.remaining, got.remaining);
                mismatches++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, actual %0d", want.last, got.last);
                mismatches++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    ctb_req_if req_if ();
    ctb_cfg_if cfg_if ();
    ctb_evt_if evt_if ();

    countdown_timer_bank_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .i_cfg   (cfg_if),
        .o_evt   (evt_if)
    );

    timer_bank_shadow bank = new();

    bit              req_on;
    int              burst_left;
    int              hold_asks = 0;
    int              cur_mpc;
    logic [TIME_W-1:0] wall_us;
    int              quiet_cycles = 0;

    always #6 i_clk = ~i_clk;

    // offer one request; bursts in which valid stays high between requests, separated by random gaps
    task automatic send_req(logic [REQ_W-1:0] kind, logic [TIMER_W-1:0] idx,
                            logic [COUNT_W-1:0] cnt, logic [TIME_W-1:0] now);
        int gap;
        if (!req_on) begin
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 6);
        end
        req_if.valid       <= 1'b1;
        req_if.req_type    <= kind;
        req_if.timer_index <= idx;
        req_if.start_count <= cnt;
        req_if.now_us      <= now;
        do @(posedge i_clk); while (!req_if.ready);
        bank.note_request(kind, idx, cnt, now);
        burst_left--;
        if (burst_left <= 0) begin
            req_if.valid <= 1'b0;
            req_on = 1'b0;
        end else begin
            req_on = 1'b1;
        end
    endtask

    task automatic end_burst();
        if (req_on) begin
            req_if.valid <= 1'b0;
            req_on = 1'b0;
        end
    endtask

    task automatic drain();
        end_burst();
        while (bank.pending() != 0) @(posedge i_clk);
    endtask

    // both registers, written only once the bank has gone quiet
    task automatic write_regs(logic [MPC_W-1:0] mpc, logic [TIMER_W-1:0] prot);
        drain();
        repeat (IDLE_SETTLE) @(posedge i_clk);
        cfg_if.valid     <= 1'b1;
        cfg_if.reg_index <= REG_MPC;
        cfg_if.wr_data   <= CFG_DATA_W'(mpc);
        do @(posedge i_clk); while (!cfg_if.ready);
        bank.set_reg(REG_MPC, CFG_DATA_W'(mpc));
        cfg_if.reg_index <= REG_PROT;
        cfg_if.wr_data   <= CFG_DATA_W'(prot);
        do @(posedge i_clk); while (!cfg_if.ready);
        bank.set_reg(REG_PROT, CFG_DATA_W'(prot));
        cfg_if.valid <= 1'b0;
        cur_mpc = int'(mpc);
    endtask

    // mostly start/tick traffic on an advancing clock so timers get serviced and expire
    task automatic run_random_phase(int n_items);
        int                 pick;
        logic [REQ_W-1:0]   kind;
        logic [TIMER_W-1:0] idx;
        logic [COUNT_W-1:0] cnt;
        logic [TIME_W-1:0]  now;
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 99);
            idx  = TIMER_W'(($urandom_range(0, 9) == 0) ? $urandom_range(NUM_TIMERS, 31)
                                                        : $urandom_range(0, NUM_TIMERS - 1));
            cnt  = COUNT_W'($urandom_range(1, 6));
            now  = wall_us;
            if (pick < 30) begin
                kind    = REQ_TICK;
                wall_us = wall_us
                        + TIME_W'($urandom_range(cur_mpc / 2, cur_mpc + cur_mpc / 2));
                now     = wall_us;
            end else if (pick < 60) begin
                kind = REQ_START;
                case ($urandom_range(0, 9))
                    0:       cnt = '0;
                    1:       cnt = COUNT_W'($urandom_range(0, 65535));
                    default: ;
                endcase
            end else if (pick < 70) begin
                kind = REQ_QUERY;
            end else if (pick < 78) begin
                kind = REQ_STOP;
            end else if (pick < 86) begin
                kind = REQ_TRIP;
            end else if (pick < 91) begin
                kind = REQ_CLEAR;
            end else begin
                kind = REQ_W'($urandom_range(0, 7));
                idx  = TIMER_W'($urandom_range(0, 31));
                cnt  = COUNT_W'($urandom_range(0, 65535));
                now  = TIME_W'({$urandom, $urandom});
            end
            send_req(kind, idx, cnt, now);
        end
    endtask

    // event sink: the stall pattern is redrawn after each random-length run, long hold-off on request
    initial begin : evt_sink
        int mode;
        int left;
        int holds_done;
        mode       = 0;
        left       = 0;
        holds_done = 0;
        evt_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_asks != holds_done) begin
                holds_done = hold_asks;
                evt_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(16, 96);
                end
                left--;
                case (mode)
                    0:       evt_if.ready <= 1'b1;
                    1:       evt_if.ready <= 1'($urandom_range(0, 1));
                    2:       evt_if.ready <= ($urandom_range(0, 3) == 0);
                    default: evt_if.ready <= ~evt_if.ready;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && evt_if.valid && evt_if.ready)
            bank.check_event({evt_if.event_kind, evt_if.event_timer,
                              evt_if.remaining, evt_if.last});
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (evt_if.valid && evt_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_countdown_timer_bank_top: FAIL");
                $finish;
            end
        end
    end

    initial begin : stimulus
        i_rst_n            <= 1'b0;
        req_if.valid       <= 1'b0;
        req_if.req_type    <= REQ_START;
        req_if.timer_index <= '0;
        req_if.start_count <= '0;
        req_if.now_us      <= '0;
        cfg_if.valid       <= 1'b0;
        cfg_if.reg_index   <= REG_MPC;
        cfg_if.wr_data     <= '0;
        req_on       = 1'b0;
        burst_left   = 0;
        cur_mpc      = int'(MPC_RESET);
        wall_us      = TIME_W'({$urandom_range(0, 255), $urandom});
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: clamp of zero count, out-of-range index, decrement to zero
        send_req(REQ_QUERY, 5'd0, '0, '0);
        send_req(REQ_QUERY, 5'd31, '0, '0);
        send_req(REQ_START, 5'd0, 16'd0, '0);
        send_req(REQ_START, 5'd19, 16'hFFFF, '0);
        send_req(REQ_START, 5'd11, 16'd3, '0);
        send_req(REQ_START, 5'd31, 16'd5, '0);
        send_req(REQ_TICK, '0, '0, 48'd5000);
        send_req(REQ_TICK, '0, '0, 48'd5000);
        send_req(REQ_TRIP, 5'd19, '0, '0);
        send_req(REQ_STOP, 5'd11, '0, '0);
        send_req(REQ_TRIP, 5'd25, '0, '0);
        send_req(REQ_STOP, 5'd20, '0, '0);
        send_req(REQ_START, 5'd5, 16'd2, 48'd10);
        send_req(REQ_START, 5'd11, 16'd4, 48'd10);
        send_req(REQ_CLEAR, '0, '0, '0);
        send_req(REQ_QUERY, 5'd11, '0, '0);
        send_req(REQ_SPARE_A, 5'd3, 16'd9, '0);
        send_req(REQ_SPARE_B, 5'd3, 16'd9, '0);
        send_req(REQ_TICK, '0, '0, TIME_MAX);
        send_req(REQ_TICK, '0, '0, '0);

        // zero scale: deadline equals now, so the next tick trips silently
        write_regs('0, 5'd0);
        send_req(REQ_START, 5'd3, 16'd7, 48'd100);
        send_req(REQ_START, 5'd0, 16'd2, 48'd100);
        send_req(REQ_CLEAR, '0, '0, '0);
        send_req(REQ_TICK, '0, '0, 48'd100);
        send_req(REQ_TICK, '0, '0, 48'd100);

        // largest scale near the top of time: deadline saturates; clear_all protects none
        write_regs({MPC_W{1'b1}}, 5'd31);
        send_req(REQ_START, 5'd2, 16'hFFFF, TIME_MAX - 48'd15);
        send_req(REQ_TICK, '0, '0, TIME_MAX - 48'd1);
        send_req(REQ_START, 5'd7, 16'd1, '0);
        send_req(REQ_CLEAR, '0, '0, '0);
        send_req(REQ_TICK, '0, '0, '0);

        write_regs(20'd1, 5'd19);
        run_random_phase(RANDOM_PER_PHASE);
        write_regs(20'd1000000, 5'd20);
        run_random_phase(RANDOM_PER_PHASE);
        write_regs(MPC_W'($urandom_range(1, 1000000)), TIMER_W'($urandom_range(0, 31)));
        hold_asks = hold_asks + 1;
        run_random_phase(RANDOM_PER_PHASE);
        write_regs(MPC_W'($urandom_range(1000, 20000)), TIMER_W'($urandom_range(0, 31)));
        run_random_phase(RANDOM_PER_PHASE);

        drain();
        repeat (END_SETTLE) @(posedge i_clk);
        if (bank.mismatches == 0) begin
            $display("tb_countdown_timer_bank_top: PASS");
        end else begin
            $display("tb_countdown_timer_bank_top: FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/ctb_pkg.sv
rtl/core/ctb_intf.sv
rtl/core/ctb_ram.sv
rtl/core/countdown_timer_bank_top.sv
sim/tb_countdown_timer_bank_top.sv
